FILE: rtl/stth_pkg.sv
package stth_pkg;

   localparam int FIFO_DEPTH  = 1024;   // power of two
   localparam int ADDR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int MAX_CHUNK   = 22;
   localparam int LEN_W       = 5;
   localparam int QUEUE_DEPTH = 2;     // power of two
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_W-1:0] CHUNK_LIMIT_RESET = LEN_W'(MAX_CHUNK);

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CYCLE = 1'b1;

   localparam logic [1:0] KIND_PUSH_ACK = 2'd0;
   localparam logic [1:0] KIND_CONTROL  = 2'd1;
   localparam logic [1:0] KIND_DATA     = 2'd2;

   typedef struct packed {
      logic             command;
      logic [7:0]       tx_byte;
      logic             push_last;
      logic             status_transmit_accepted;
      logic             status_receive_request;
      logic             status_init_accepted;
      logic [LEN_W-1:0] status_input_length;
   } req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic             push_accepted;
      logic             init_req;
      logic             transmit_toggle;
      logic             receive_ack_toggle;
      logic [LEN_W-1:0] tx_len;
      logic             receive_event;
      logic [LEN_W-1:0] received_length;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] data_index;
      logic             last;
   } rsp_type;

   typedef enum logic {
      OP_PUSH,
      OP_CYCLE
   } op_type;

   // Classified item as it waits between front and back
   typedef struct packed {
      op_type           op;
      logic [7:0]       tx_byte;
      logic             push_last;
      logic             tx_ack_bit;
      logic             rx_req_bit;
      logic             init_ack_bit;
      logic [LEN_W-1:0] rx_avail_len;
   } item_type;

endpackage

FILE: rtl/serial_terminal_toggle_handshake_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data  (push byte or process-data cycle)
// rsp_      out        rsp_valid/rsp_stall  rsp_data  (push ack, control word, chunk bytes)
// csr_      in         csr_write            csr_wdata (chunk_limit)
//
// A push yields one push ack from the back end; a cycle item yields a control word
// followed by its chunk bytes, 22 at most, paced by the single read port of the
// transmit FIFO memory. A two-entry queue decouples intake.
// Reset is synchronous; the FIFO memory is not cleared, chunk_limit returns to 22.
// A stalled result holds in the output register, and no further item is taken until it is accepted.
module serial_terminal_toggle_handshake_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  stth_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output stth_pkg::rsp_type           rsp_data,
   input  logic                        csr_write,
   input  logic [stth_pkg::LEN_W-1:0]  csr_wdata
);
   import stth_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   stth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   stth_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/stth_front.sv
module stth_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stth_pkg::req_type req_data,
   output logic              q_valid,
   output stth_pkg::item_type q_item,
   input  logic              q_pop
);
   import stth_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                accept;
   item_type            classified;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      classified.op           = (req_data.command == CMD_PUSH) ? OP_PUSH : OP_CYCLE;
      classified.tx_byte      = req_data.tx_byte;
      classified.push_last    = req_data.push_last;
      classified.tx_ack_bit   = req_data.status_transmit_accepted;
      classified.rx_req_bit   = req_data.status_receive_request;
      classified.init_ack_bit = req_data.status_init_accepted;
      classified.rx_avail_len = req_data.status_input_length;
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/stth_back.sv
module stth_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  stth_pkg::item_type          q_item,
   output logic                        q_pop,
   input  logic                        csr_write,
   input  logic [stth_pkg::LEN_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output stth_pkg::rsp_type           rsp_data
);
   import stth_pkg::*;

   typedef enum logic {
      ST_EXEC,
      ST_DATA
   } state_type;

   typedef enum logic [1:0] {
      PH_INIT_ENTER,
      PH_INIT_RUN,
      PH_IDLE,
      PH_WAIT
   } phase_type;

   logic [7:0]        fifo_mem [FIFO_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic              full_ff, full_in;
   logic              init_ff, init_in;
   logic              ttog_ff, ttog_in;
   logic              rtog_ff, rtog_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;
   logic              seen_ff, seen_in;
   logic              saved_ff, saved_in;
   logic              pending_ff, pending_in;
   logic [LEN_W-1:0]  limit_ff, limit_in;
   logic [LEN_W-1:0]  chunk_len_ff, chunk_len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [CNT_W-1:0]  fifo_count;
   logic [LEN_W-1:0]  eff_limit;
   logic [LEN_W-1:0]  chunk_n;
   logic              send;
   logic              rx_event;
   logic [LEN_W-1:0]  rx_len;
   logic              data_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_EXEC) && q_valid && out_free;
   assign mem_we    = q_pop && (q_item.op == OP_PUSH) && !full_ff;

   assign fifo_count = full_ff ? CNT_W'(FIFO_DEPTH) : {1'b0, head_ff - tail_ff};

   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = LEN_W'(1);
      end else if (limit_ff > LEN_W'(MAX_CHUNK)) begin
         eff_limit = LEN_W'(MAX_CHUNK);
      end else begin
         eff_limit = limit_ff;
      end
      chunk_n = (fifo_count < CNT_W'(eff_limit)) ? fifo_count[LEN_W-1:0] : eff_limit;
   end

   assign data_last = (idx_ff + LEN_W'(1)) == chunk_len_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rd_ptr_in    = rd_ptr_ff;
      full_in      = full_ff;
      init_in      = init_ff;
      ttog_in      = ttog_ff;
      rtog_in      = rtog_ff;
      olen_in      = olen_ff;
      seen_in      = seen_ff;
      saved_in     = saved_ff;
      pending_in   = pending_ff;
      limit_in     = csr_write ? csr_wdata : limit_ff;
      chunk_len_in = chunk_len_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      send         = 1'b0;
      rx_event     = 1'b0;
      rx_len       = '0;

      case (state_ff)
         ST_EXEC: begin
            if (q_pop && q_item.op == OP_PUSH) begin
               if (!full_ff) begin
                  head_in = head_ff + 1'b1;
                  full_in = (head_in == tail_ff);
                  if (q_item.push_last) begin
                     pending_in = 1'b1;
                  end
               end
               rsp_valid_in              = 1'b1;
               rsp_data_in               = '0;
               rsp_data_in.result_kind   = KIND_PUSH_ACK;
               rsp_data_in.push_accepted = !full_ff;
               rsp_data_in.last          = 1'b1;
            end else if (q_pop) begin
               case (phase_ff)
                  PH_INIT_ENTER: begin
                     init_in  = 1'b1;
                     phase_in = PH_INIT_RUN;
                  end
                  PH_INIT_RUN: begin
                     if (init_ff && q_item.init_ack_bit) begin
                        init_in = 1'b0;
                     end else if (!init_ff && !q_item.init_ack_bit) begin
                        phase_in = PH_IDLE;
                        rtog_in  = q_item.rx_req_bit;
                        seen_in  = q_item.rx_req_bit;
                     end
                  end
                  PH_IDLE: begin
                     if (q_item.rx_req_bit != seen_ff) begin
                        seen_in  = q_item.rx_req_bit;
                        rtog_in  = !rtog_ff;
                        rx_event = 1'b1;
                        rx_len   = q_item.rx_avail_len;
                     end
                     send = pending_ff;
                  end
                  PH_WAIT: begin
                     if (saved_ff != q_item.tx_ack_bit) begin
                        if (fifo_count == '0) begin
                           pending_in = 1'b0;
                           phase_in   = PH_IDLE;
                        end else begin
                           send = 1'b1;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_INIT_ENTER;
                  end
               endcase

               chunk_len_in = '0;
               if (send) begin
                  // tail jumps now; rd_ptr walks the chunk afterwards
                  tail_in      = tail_ff + ADDR_W'(chunk_n);
                  if (chunk_n != '0) begin
                     full_in = 1'b0;
                  end
                  olen_in      = chunk_n;
                  saved_in     = q_item.tx_ack_bit;
                  ttog_in      = !ttog_ff;
                  phase_in     = PH_WAIT;
                  chunk_len_in = chunk_n;
               end

               rsp_valid_in                   = 1'b1;
               rsp_data_in                    = '0;
               rsp_data_in.result_kind        = KIND_CONTROL;
               rsp_data_in.init_req           = init_in;
               rsp_data_in.transmit_toggle    = ttog_in;
               rsp_data_in.receive_ack_toggle = rtog_in;
               rsp_data_in.tx_len             = olen_in;
               rsp_data_in.receive_event      = rx_event;
               rsp_data_in.received_length    = rx_len;
               rsp_data_in.last               = (chunk_len_in == '0);
               idx_in                         = '0;
               if (chunk_len_in != '0) begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = '0;
               rsp_data_in.result_kind  = KIND_DATA;
               rsp_data_in.data_byte    = rd_data_ff;
               rsp_data_in.data_index   = idx_ff;
               rsp_data_in.last         = data_last;
               rd_ptr_in                = rd_ptr_ff + 1'b1;
               idx_in                   = idx_ff + LEN_W'(1);
               if (data_last) begin
                  state_in = ST_EXEC;
               end
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   // read address follows rd_ptr_in so the next byte is registered in rd_data_ff by the time rd_ptr_ff reaches it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[head_ff] <= q_item.tx_byte;
      end
      rd_data_ff <= fifo_mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      chunk_len_ff <= chunk_len_in;
      idx_ff       <= idx_in;
      if (reset) begin
         state_ff     <= ST_EXEC;
         phase_ff     <= PH_INIT_ENTER;
         head_ff      <= '0;
         tail_ff      <= '0;
         rd_ptr_ff    <= '0;
         full_ff      <= 1'b0;
         init_ff      <= 1'b0;
         ttog_ff      <= 1'b0;
         rtog_ff      <= 1'b0;
         olen_ff      <= '0;
         seen_ff      <= 1'b0;
         saved_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         limit_ff     <= CHUNK_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rd_ptr_ff    <= rd_ptr_in;
         full_ff      <= full_in;
         init_ff      <= init_in;
         ttog_ff      <= ttog_in;
         rtog_ff      <= rtog_in;
         olen_ff      <= olen_in;
         seen_ff      <= seen_in;
         saved_ff     <= saved_in;
         pending_ff   <= pending_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/stth_checker.sv
module stth_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input stth_pkg::rsp_type           rsp_data
);
   import stth_pkg::*;

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_push_ack_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_PUSH_ACK |->
         rsp_data.last && rsp_data.tx_len == '0 && !rsp_data.init_req &&
         rsp_data.data_byte == '0 && !rsp_data.receive_event)
      else $error("push ack carries control or data fields");

   a_rx_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_CONTROL && !rsp_data.receive_event |->
         rsp_data.received_length == '0)
      else $error("received length without receive event");

   a_chunk_start: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_data.result_kind == KIND_CONTROL && !rsp_data.last |=>
         rsp_valid && rsp_data.result_kind == KIND_DATA && rsp_data.data_index == '0)
      else $error("chunk did not follow control word");

   a_chunk_next: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_data.result_kind == KIND_DATA && !rsp_data.last |=>
         rsp_valid && rsp_data.result_kind == KIND_DATA &&
         rsp_data.data_index == $past(rsp_data.data_index) + LEN_W'(1))
      else $error("chunk byte sequence broken");

endmodule

bind serial_terminal_toggle_handshake_unit stth_checker u_stth_checker (.*);

FILE: tb/serial_terminal_toggle_handshake_unit_tb.sv
`timescale 1ns / 1ps

module serial_terminal_toggle_handshake_unit_tb;
   import stth_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 32;
   localparam int RANDOM_ITEMS   = 160;
   localparam int REQ_W          = $bits(req_type);

   typedef enum logic [1:0] {
      LINK_INIT_START,
      LINK_INIT_WAIT,
      LINK_IDLE,
      LINK_AWAIT_ACK
   } link_phase_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write;
   logic [LEN_W-1:0] csr_wdata;

   serial_terminal_toggle_handshake_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Gateway state as the terminal link sees it
   logic [7:0]        tx_mem [FIFO_DEPTH];
   logic [ADDR_W-1:0] tx_head;
   logic [ADDR_W-1:0] tx_tail;
   logic              tx_full;
   logic              tx_pending;
   link_phase_type    link_phase;
   logic              init_req_q;
   logic              tx_toggle_q;
   logic              rx_toggle_q;
   logic              seen_rr_q;
   logic              saved_ta_q;
   logic [LEN_W-1:0]  out_len_q;
   logic [LEN_W-1:0]  chunk_limit_q;
   logic [7:0]        chunk_bytes [$];
   rsp_type           rsps_due [$];

   int send_idle_pct = 6;
   int recv_idle_pct = 47;
   int mismatch_count = 0;
   int stuck_cycles = 0;
   int push_count = 0;
   int refused_pushes = 0;
   int cycle_count = 0;
   int rx_ack_count = 0;
   int chunks_sent = 0;
   int chunk_byte_count = 0;
   int limit_writes = 0;

   function automatic int tx_fill();
      logic [ADDR_W-1:0] span;
      span = tx_head - tx_tail;
      return tx_full ? FIFO_DEPTH : int'(span);
   endfunction

   function automatic void take_chunk(input logic ta);
      int lim;
      int fill;
      int n;
      lim = int'(chunk_limit_q);
      if (lim == 0) begin
         lim = 1;
      end
      if (lim > MAX_CHUNK) begin
         lim = MAX_CHUNK;
      end
      fill = tx_fill();
      n = (fill < lim) ? fill : lim;
      chunk_bytes.delete();
      for (int i = 0; i < n; i++) begin
         chunk_bytes.push_back(tx_mem[tx_tail]);
         tx_tail = tx_tail + 1'b1;
      end
      if (n > 0) begin
         tx_full = 1'b0;
      end
      out_len_q = LEN_W'(n);
      saved_ta_q = ta;
      tx_toggle_q = ~tx_toggle_q;
      link_phase = LINK_AWAIT_ACK;
      chunks_sent++;
   endfunction

   function automatic void advance_gateway(input req_type item);
      rsp_type          word;
      logic             rx_event;
      logic [LEN_W-1:0] rx_len;
      word = '0;
      rx_event = 1'b0;
      rx_len = '0;
      chunk_bytes.delete();
      if (item.command == CMD_PUSH) begin
         word.result_kind = KIND_PUSH_ACK;
         word.push_accepted = ~tx_full;
         word.last = 1'b1;
         if (!tx_full) begin
            tx_mem[tx_head] = item.tx_byte;
            tx_head = tx_head + 1'b1;
            tx_full = (tx_head == tx_tail);
            if (item.push_last) begin
               tx_pending = 1'b1;
            end
         end else begin
            refused_pushes++;
         end
         push_count++;
         rsps_due.push_back(word);
         return;
      end
      cycle_count++;
      case (link_phase)
         LINK_INIT_START: begin
            init_req_q = 1'b1;
            link_phase = LINK_INIT_WAIT;
         end
         LINK_INIT_WAIT: begin
            if (init_req_q && item.status_init_accepted) begin
               init_req_q = 1'b0;
            end else if (!init_req_q && !item.status_init_accepted) begin
               link_phase = LINK_IDLE;
               rx_toggle_q = item.status_receive_request;
               seen_rr_q = item.status_receive_request;
            end
         end
         LINK_IDLE: begin
            if (item.status_receive_request != seen_rr_q) begin
               seen_rr_q = item.status_receive_request;
               rx_toggle_q = ~rx_toggle_q;
               rx_event = 1'b1;
               rx_len = item.status_input_length;
               rx_ack_count++;
            end
            if (tx_pending) begin
               take_chunk(item.status_transmit_accepted);
            end
         end
         default: begin
            // receive request is ignored while a chunk awaits acknowledgement
            if (saved_ta_q != item.status_transmit_accepted) begin
               if (tx_fill() == 0) begin
                  tx_pending = 1'b0;
                  link_phase = LINK_IDLE;
               end else begin
                  take_chunk(item.status_transmit_accepted);
               end
            end
         end
      endcase
      word.result_kind = KIND_CONTROL;
      word.init_req = init_req_q;
      word.transmit_toggle = tx_toggle_q;
      word.receive_ack_toggle = rx_toggle_q;
      word.tx_len = out_len_q;
      word.receive_event = rx_event;
      word.received_length = rx_len;
      word.last = (chunk_bytes.size() == 0);
      rsps_due.push_back(word);
      foreach (chunk_bytes[i]) begin
         word = '0;
         word.result_kind = KIND_DATA;
         word.data_byte = chunk_bytes[i];
         word.data_index = LEN_W'(i);
         word.last = (i == chunk_bytes.size() - 1);
         rsps_due.push_back(word);
      end
      chunk_byte_count += chunk_bytes.size();
   endfunction

   function automatic req_type make_push(input logic [7:0] b, input logic last_byte);
      req_type item;
      item = '0;
      item.command = CMD_PUSH;
      item.tx_byte = b;
      item.push_last = last_byte;
      return item;
   endfunction

   function automatic req_type make_cycle(input logic ta, input logic rr, input logic ia,
                                          input logic [LEN_W-1:0] len);
      req_type item;
      item = '0;
      item.command = CMD_CYCLE;
      item.status_transmit_accepted = ta;
      item.status_receive_request = rr;
      item.status_init_accepted = ia;
      item.status_input_length = len;
      return item;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   // One transfer on the request channel; returns at the accepting edge with valid still high
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_gateway(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rsps_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_chunk_limit(input logic [LEN_W-1:0] value);
      wait_idle();
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      chunk_limit_q = value;
      csr_write <= 1'b0;
      limit_writes++;
   endtask

   task automatic drain_transmit();
      while (tx_pending || link_phase == LINK_AWAIT_ACK) begin
         send_item(make_cycle(tx_toggle_q, seen_rr_q, 1'b0, '0));
      end
   endtask

   task automatic test_init_handshake();
      // bytes pushed before the link is up are held
      send_item(make_push(8'h00, 1'b0));
      send_item(make_push(8'hFF, 1'b1));
      send_item(make_cycle(1'b0, 1'b0, 1'b0, '0));
      send_item(make_cycle(1'b0, 1'b0, 1'b0, '0));
      send_item(make_cycle(1'b0, 1'b0, 1'b1, '0));
      send_item(make_cycle(1'b0, 1'b0, 1'b1, '0));
      send_item(make_cycle(1'b0, 1'b1, 1'b0, '0));
   endtask

   task automatic test_chunk_limit_zero();
      write_chunk_limit('0);
      send_item(make_push(8'hA5, 1'b0));
      send_item(make_push(8'h5A, 1'b0));
      send_item(make_push(8'h3C, 1'b1));
      drain_transmit();
   endtask

   task automatic test_receive_toggles();
      logic rr;
      write_chunk_limit(CHUNK_LIMIT_RESET);
      rr = ~seen_rr_q;
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, 5'd22));
      rr = ~rr;
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, 5'd0));
      rr = ~rr;
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, 5'd31));
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, 5'd5));
      send_item(make_push(8'h80, 1'b0));
      send_item(make_push(8'h01, 1'b1));
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, '0));
      rr = ~rr;
      // toggle arrives while the chunk is unacknowledged
      send_item(make_cycle(saved_ta_q, rr, 1'b0, 5'd9));
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, 5'd9));
      send_item(make_cycle(tx_toggle_q, rr, 1'b0, 5'd17));
   endtask

   task automatic test_fifo_full();
      write_chunk_limit(5'd31);
      send_item(make_push(8'h11, 1'b1));
      while (!tx_full) begin
         send_item(make_push(8'($urandom), 1'b0));
      end
      send_item(make_push(8'hFF, 1'b1));
      send_item(make_push(8'h00, 1'b0));
      send_item(make_push(8'($urandom), 1'b1));
      drain_transmit();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [LEN_W-1:0] limit);
      req_type item;
      logic    term_ta;
      logic    term_rr;
      int      roll;
      write_chunk_limit(limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      term_ta = tx_toggle_q;
      term_rr = seen_rr_q;
      repeat (RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            item = REQ_W'($urandom);
         end else if (roll < 55) begin
            item = make_push(8'($urandom), $urandom_range(5) == 0);
         end else begin
            // terminal mostly acknowledges the latest chunk
            if ($urandom_range(3) != 0) begin
               term_ta = tx_toggle_q;
            end
            if ($urandom_range(9) < 3) begin
               term_rr = ~term_rr;
            end
            item = make_cycle(term_ta, term_rr, init_req_q ^ ($urandom_range(19) == 0),
                              ($urandom_range(9) == 0) ? LEN_W'($urandom_range(31))
                                                       : LEN_W'($urandom_range(MAX_CHUNK)));
            item.tx_byte = 8'($urandom);
            item.push_last = 1'($urandom_range(1));
         end
         send_item(item);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   rsp_type due;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (rsps_due.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
         end else begin
            due = rsps_due.pop_front();
            check_field("result_kind", 8'(rsp_data.result_kind), 8'(due.result_kind));
            check_field("push_accepted", 8'(rsp_data.push_accepted),
                        8'(due.push_accepted));
            check_field("init_req", 8'(rsp_data.init_req), 8'(due.init_req));
            check_field("transmit_toggle", 8'(rsp_data.transmit_toggle),
                        8'(due.transmit_toggle));
            check_field("receive_ack_toggle", 8'(rsp_data.receive_ack_toggle),
                        8'(due.receive_ack_toggle));
            check_field("tx_len", 8'(rsp_data.tx_len), 8'(due.tx_len));
            check_field("receive_event", 8'(rsp_data.receive_event),
                        8'(due.receive_event));
            check_field("received_length", 8'(rsp_data.received_length),
                        8'(due.received_length));
            check_field("data_byte", rsp_data.data_byte, due.data_byte);
            check_field("data_index", 8'(rsp_data.data_index), 8'(due.data_index));
            check_field("last", 8'(rsp_data.last), 8'(due.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL serial_terminal_toggle_handshake_unit");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_write <= 1'b0;
      csr_wdata <= '0;
      tx_head = '0;
      tx_tail = '0;
      tx_full = 1'b0;
      tx_pending = 1'b0;
      link_phase = LINK_INIT_START;
      init_req_q = 1'b0;
      tx_toggle_q = 1'b0;
      rx_toggle_q = 1'b0;
      seen_rr_q = 1'b0;
      saved_ta_q = 1'b0;
      out_len_q = '0;
      chunk_limit_q = CHUNK_LIMIT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_init_handshake();
      test_chunk_limit_zero();
      test_receive_toggles();
      test_fifo_full();
      test_random_traffic(6, 47, 5'd1);
      test_random_traffic(47, 6, LEN_W'($urandom_range(2, MAX_CHUNK - 1)));
      test_random_traffic(0, 0, LEN_W'($urandom_range(31)));
      wait_idle();

      $display("Covered init handshake, %0d pushes (%0d refused while full), %0d link cycles",
               push_count, refused_pushes, cycle_count);
      $display("%0d receive acks, %0d chunks carrying %0d bytes, %0d chunk limit writes",
               rx_ack_count, chunks_sent, chunk_byte_count, limit_writes);
      if (mismatch_count == 0) begin
         $display("PASS serial_terminal_toggle_handshake_unit");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL serial_terminal_toggle_handshake_unit");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/stth_pkg.sv
rtl/stth_front.sv
rtl/stth_back.sv
rtl/serial_terminal_toggle_handshake_unit.sv
rtl/stth_checker.sv
tb/serial_terminal_toggle_handshake_unit_tb.sv
